// ===== rtl/core/uart_receiver_with_fifo_defines.svh =====
// assertion macros for the uart receiver with receive fifo
`ifndef UART_RECEIVER_WITH_FIFO_DEFINES_SVH
`define UART_RECEIVER_WITH_FIFO_DEFINES_SVH

// same-cycle implication, disabled during reset
`define URF_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("urf assertion failed");

// next-cycle implication, disabled during reset
`define URF_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("urf assertion failed");

`endif

// ===== rtl/core/urf_pkg.sv =====
// shared types and constants for the uart receiver with receive fifo
`timescale 1ns / 1ps
`default_nettype none

package urf_pkg;

  localparam int unsigned URF_FIFO_DEPTH = 64;
  localparam int unsigned URF_DATA_W     = 8;
  localparam int unsigned URF_CNT_W      = 6;
  localparam int unsigned URF_BT_W       = 16;
  localparam int unsigned URF_MID_DEPTH  = 2;
  localparam int unsigned URF_OUT_DEPTH  = 4;
  localparam logic [URF_BT_W-1:0] URF_BAUD_TICKS_RESET = 16'd104;
  localparam logic [3:0] URF_NUM_BITS = 4'd8;

  // request kinds passed from front to back
  typedef enum logic [1:0] {
    OP_TICK,
    OP_PUSH,
    OP_READ
  } op_kind_e;

  typedef struct packed {
    op_kind_e                kind;
    logic [URF_DATA_W-1:0]   data;
  } op_t;

  typedef struct packed {
    logic [URF_DATA_W-1:0] data;
    logic                  valid;
    logic [URF_CNT_W-1:0]  stored;
    logic                  ovf;
    logic                  done;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/urf_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module urf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/urf_front.sv =====
// front end: bit-timing state machine and request queue toward the fifo side
`timescale 1ns / 1ps
`default_nettype none

module urf_front import urf_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [URF_BT_W-1:0] baud_ticks_i,
  input  wire logic                push,
  input  wire logic                command_i,
  input  wire logic                rx_level_i,
  output logic                     full,
  output logic                     op_valid_o,
  output op_t                      op_o,
  input  wire logic                op_ready_i
);

  localparam int unsigned MW = $clog2(URF_MID_DEPTH);
  localparam int unsigned CW = $clog2(URF_MID_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HALF,
    PH_DATA,
    PH_STOP
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [URF_BT_W-1:0]     tcnt_q, tcnt_d;
  logic [3:0]              bidx_q, bidx_d;
  logic [URF_DATA_W-1:0]   shift_q, shift_d;
  logic                    last_q, last_d;

  logic                    accept, tick, done;
  logic [URF_BT_W-1:0]     tcnt_inc, half_time;
  logic [3:0]              bidx_inc;
  op_t                     op_new;

  op_t                     mq_q [URF_MID_DEPTH];
  logic [MW-1:0]           mq_head_q, mq_tail_q;
  logic [CW-1:0]           mq_cnt_q;
  logic                    mq_pop;

  assign full      = (mq_cnt_q == CW'(URF_MID_DEPTH));
  assign accept    = push && !full;
  assign tick      = accept && !command_i;
  assign tcnt_inc  = tcnt_q + URF_BT_W'(1);
  assign bidx_inc  = bidx_q + 4'd1;
  assign half_time = baud_ticks_i >> 1;

  always_comb begin
    phase_d = phase_q;
    tcnt_d  = tcnt_q;
    bidx_d  = bidx_q;
    shift_d = shift_q;
    last_d  = last_q;
    done    = 1'b0;
    if (tick) begin
      last_d = rx_level_i;
      unique case (phase_q)
        PH_IDLE: begin
          // falling edge starts a frame
          if (last_q && !rx_level_i) begin
            tcnt_d  = '0;
            bidx_d  = '0;
            shift_d = '0;
            phase_d = (half_time == '0) ? PH_DATA : PH_HALF;
          end
        end
        PH_HALF: begin
          tcnt_d = tcnt_inc;
          if (tcnt_inc >= half_time) begin
            tcnt_d  = '0;
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          tcnt_d = tcnt_inc;
          if (tcnt_inc >= baud_ticks_i) begin
            tcnt_d  = '0;
            shift_d = {rx_level_i, shift_q[URF_DATA_W-1:1]};
            bidx_d  = bidx_inc;
            if (bidx_inc >= URF_NUM_BITS) begin
              done    = 1'b1;
              phase_d = PH_STOP;
            end
          end
        end
        PH_STOP: begin
          tcnt_d = tcnt_inc;
          if (tcnt_inc >= baud_ticks_i) begin
            tcnt_d  = '0;
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tcnt_q  <= '0;
      bidx_q  <= '0;
      shift_q <= '0;
      last_q  <= 1'b1;
    end else begin
      phase_q <= phase_d;
      tcnt_q  <= tcnt_d;
      bidx_q  <= bidx_d;
      shift_q <= shift_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    op_new.data = shift_d;
    if (command_i) begin
      op_new.kind = OP_READ;
    end else if (done) begin
      op_new.kind = OP_PUSH;
    end else begin
      op_new.kind = OP_TICK;
    end
  end

  // request queue
  assign op_valid_o = (mq_cnt_q != '0);
  assign op_o       = mq_q[mq_head_q];
  assign mq_pop     = op_valid_o && op_ready_i;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mq_q[mq_tail_q] <= op_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mq_head_q <= '0;
      mq_tail_q <= '0;
      mq_cnt_q  <= '0;
    end else begin
      if (accept) begin
        mq_tail_q <= mq_tail_q + MW'(1);
      end
      if (mq_pop) begin
        mq_head_q <= mq_head_q + MW'(1);
      end
      if (accept && !mq_pop) begin
        mq_cnt_q <= mq_cnt_q + CW'(1);
      end else if (!accept && mq_pop) begin
        mq_cnt_q <= mq_cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/urf_back.sv =====
// back end: byte fifo pointers, storage and result queue
`timescale 1ns / 1ps
`default_nettype none

module urf_back import urf_pkg::*; #(
  parameter int unsigned FifoDepth = URF_FIFO_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic op_valid_i,
  input  wire op_t  op_i,
  output logic      op_ready_o,
  output logic      empty,
  input  wire logic pop,
  output res_t      res_o
);

  localparam int unsigned AW  = $clog2(FifoDepth);
  localparam int unsigned XW  = (AW > URF_CNT_W) ? AW : URF_CNT_W;
  localparam int unsigned OW  = $clog2(URF_OUT_DEPTH);
  localparam int unsigned OCW = $clog2(URF_OUT_DEPTH + 1);

  logic [AW-1:0]          rp_q, rp_d, wp_q, wp_d, cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic                   issue, rd_en, wr_en, rv, dn;
  logic [XW-1:0]          cnt_ext;
  logic [URF_DATA_W-1:0]  ram_rdata;

  logic                   s2_valid_q, s2_rv_q, s2_done_q, s2_ovf_q;
  logic [URF_CNT_W-1:0]   s2_cnt_q;
  res_t                   s2_res;

  res_t                   oq_q [URF_OUT_DEPTH];
  logic [OW-1:0]          oq_head_q, oq_tail_q;
  logic [OCW-1:0]         oq_cnt_q;
  logic                   oq_pop;

  // issue only when the result queue has room for everything in flight
  assign op_ready_o = (oq_cnt_q + OCW'(s2_valid_q)) < OCW'(URF_OUT_DEPTH);
  assign issue      = op_valid_i && op_ready_o;

  always_comb begin
    rp_d  = rp_q;
    wp_d  = wp_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    rd_en = 1'b0;
    wr_en = 1'b0;
    rv    = 1'b0;
    dn    = 1'b0;
    if (issue) begin
      unique case (op_i.kind)
        OP_READ: begin
          if (cnt_q != '0) begin
            rd_en = 1'b1;
            rv    = 1'b1;
            rp_d  = (rp_q == AW'(FifoDepth - 1)) ? '0 : rp_q + AW'(1);
            cnt_d = cnt_q - AW'(1);
          end
        end
        OP_PUSH: begin
          dn = 1'b1;
          if (cnt_q != AW'(FifoDepth - 1)) begin
            wr_en = 1'b1;
            wp_d  = (wp_q == AW'(FifoDepth - 1)) ? '0 : wp_q + AW'(1);
            cnt_d = cnt_q + AW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        OP_TICK: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign cnt_ext = XW'(cnt_d);

  urf_ram #(
    .Width (URF_DATA_W),
    .Depth (FifoDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wp_q),
    .wdata_i (op_i.data),
    .re_i    (rd_en),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q       <= '0;
      wp_q       <= '0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      rp_q       <= rp_d;
      wp_q       <= wp_d;
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      s2_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_rv_q   <= rv;
    s2_done_q <= dn;
    s2_ovf_q  <= ovf_d;
    s2_cnt_q  <= cnt_ext[URF_CNT_W-1:0];
  end

  always_comb begin
    s2_res.data   = s2_rv_q ? ram_rdata : '0;
    s2_res.valid  = s2_rv_q;
    s2_res.stored = s2_cnt_q;
    s2_res.ovf    = s2_ovf_q;
    s2_res.done   = s2_done_q;
  end

  // result queue
  assign empty  = (oq_cnt_q == '0);
  assign res_o  = oq_q[oq_head_q];
  assign oq_pop = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      oq_q[oq_tail_q] <= s2_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_head_q <= '0;
      oq_tail_q <= '0;
      oq_cnt_q  <= '0;
    end else begin
      if (s2_valid_q) begin
        oq_tail_q <= oq_tail_q + OW'(1);
      end
      if (oq_pop) begin
        oq_head_q <= oq_head_q + OW'(1);
      end
      if (s2_valid_q && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + OCW'(1);
      end else if (!s2_valid_q && oq_pop) begin
        oq_cnt_q <= oq_cnt_q - OCW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/uart_receiver_with_fifo.sv =====
// top level of the 8n1 uart receiver with receive fifo
//
//   channel   direction  handshake            payload
//   request   in         push / full          command_i, rx_level_i
//   result    out        empty / pop          read_data_o, read_valid_o, bytes_stored_o,
//                                             overflow_flag_o, byte_done_o
//   config    in         cfg_we_i             cfg_wdata_i (ticks per bit)
//
// one request is taken per cycle while full is low; a result passes the request queue,
// then the fifo pointer stage with the ram read register, then the result queue
// the byte ram is written or read at most once per request through its single port pair
// reset clears all control state; the byte ram is not cleared
// full rises only when the result queue backs up because pop stays low
`timescale 1ns / 1ps
`default_nettype none
`include "uart_receiver_with_fifo_defines.svh"

module uart_receiver_with_fifo import urf_pkg::*; #(
  parameter int unsigned FifoDepth = URF_FIFO_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [URF_BT_W-1:0]   cfg_wdata_i,
  // requests
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  command_i,
  input  wire logic                  rx_level_i,
  // results
  output logic                       empty,
  input  wire logic                  pop,
  output logic [URF_DATA_W-1:0]      read_data_o,
  output logic                       read_valid_o,
  output logic [URF_CNT_W-1:0]       bytes_stored_o,
  output logic                       overflow_flag_o,
  output logic                       byte_done_o
);

  logic [URF_BT_W-1:0] baud_ticks_q;
  logic                op_valid, op_ready;
  op_t                 op;
  res_t                res;

  // bit time register, live to the timing logic
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baud_ticks_q <= URF_BAUD_TICKS_RESET;
    end else if (cfg_we_i) begin
      baud_ticks_q <= cfg_wdata_i;
    end
  end

  // front: tick timing, start detect, sampling and request classification
  urf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .baud_ticks_i (baud_ticks_q),
    .push         (push),
    .command_i    (command_i),
    .rx_level_i   (rx_level_i),
    .full         (full),
    .op_valid_o   (op_valid),
    .op_o         (op),
    .op_ready_i   (op_ready)
  );

  // back: byte fifo and in-order result queue
  urf_back #(
    .FifoDepth (FifoDepth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_ready_o (op_ready),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res)
  );

  assign read_data_o     = res.data;
  assign read_valid_o    = res.valid;
  assign bytes_stored_o  = res.stored;
  assign overflow_flag_o = res.ovf;
  assign byte_done_o     = res.done;

  // a read result never reports a finished byte
  `URF_ASSERT_IMP(a_read_not_done, clk_i, rst_ni, !empty && read_valid_o, !byte_done_o)
  // data is zero unless a stored byte came back
  `URF_ASSERT_IMP(a_data_zero, clk_i, rst_ni, !empty && !read_valid_o, read_data_o == '0)
  // overflow stays set on every later result
  `URF_ASSERT_NXT(a_ovf_sticky, clk_i, rst_ni, !empty && pop && overflow_flag_o, empty || overflow_flag_o)

endmodule

`default_nettype wire
